// ===== rtl/dvbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta vertex decoder package
// Shared command codes, queue entry and result types.
// ----------------------------------------------------------------------------
package dvbd_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;
    localparam logic [1:0] CMD_RAW    = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] word;
        logic [7:0]  byte_x;
        logic [7:0]  byte_y;
        logic [7:0]  byte_z;
        logic [2:0]  code_x;
        logic [2:0]  code_y;
        logic [2:0]  code_z;
        logic [4:0]  need;
        logic [7:0]  slot;
    } t_op;

    typedef struct packed {
        logic [7:0] vert_x;
        logic [7:0] vert_y;
        logic [7:0] vert_z;
        logic [7:0] out_slot;
        logic       underrun;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/dvbd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta vertex decoder front end
// Classify an input word and unpack its descriptor into a queue entry.
// ----------------------------------------------------------------------------
module dvbd_front (
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [dvbd_pkg::IN_DATA_W-1:0] i_data,
    output dvbd_pkg::t_op                      o_op
);

    logic [31:0] w_word;
    logic [31:0] w_desc;

    assign w_word = i_data[31:0];
    assign w_desc = i_data[63:32];

    always_comb begin
        o_op        = '0;
        o_op.cmd    = i_cmd;
        o_op.slot   = i_data[95:88];
        o_op.code_x = w_desc[8:6];
        o_op.code_y = w_desc[5:3];
        o_op.code_z = w_desc[2:0];
        o_op.need   = 5'(w_desc[8:6]) + 5'(w_desc[5:3]) + 5'(w_desc[2:0]) + 5'd3;
        case (i_cmd)
            dvbd_pkg::CMD_LOAD: begin
                o_op.word = w_word;
            end
            dvbd_pkg::CMD_DECODE: begin
                o_op.byte_x = {w_desc[31:25], 1'b0};
                o_op.byte_y = w_desc[24:17];
                o_op.byte_z = w_desc[16:9];
            end
            dvbd_pkg::CMD_RAW: begin
                o_op.byte_x = i_data[71:64];
                o_op.byte_y = i_data[79:72];
                o_op.byte_z = i_data[87:80];
            end
            default: begin
                o_op.word = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dvbd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta vertex decoder queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module dvbd_queue #(
    parameter int DEPTH = dvbd_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dvbd_pkg::t_op i_op,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_pop,
    output dvbd_pkg::t_op      o_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dvbd_pkg::t_op    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dvbd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta vertex decoder back end
// Bit buffer, axis accumulators and the registered result stage.
// ----------------------------------------------------------------------------
module dvbd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_op_valid,
    input  wire dvbd_pkg::t_op i_op,
    output logic               o_op_ready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output dvbd_pkg::t_res     o_res
);

    logic [63:0]    r_buf;
    logic [6:0]     r_cnt;
    logic [7:0]     r_acc_x;
    logic [7:0]     r_acc_y;
    logic [7:0]     r_acc_z;
    logic           r_out_valid;
    dvbd_pkg::t_res r_out;

    logic [63:0]    n_buf;
    logic [6:0]     n_cnt;
    logic [7:0]     n_acc_x;
    logic [7:0]     n_acc_y;
    logic [7:0]     n_acc_z;
    logic           n_out_valid;
    dvbd_pkg::t_res n_out;

    logic           w_has_res;
    logic           w_go;
    logic           w_underrun;
    logic [23:0]    w_top;
    logic [3:0]     w_wx;
    logic [3:0]     w_wy;
    logic [3:0]     w_wz;
    logic [23:0]    w_sh_y;
    logic [23:0]    w_sh_z;
    logic [7:0]     w_fx;
    logic [7:0]     w_fy;
    logic [7:0]     w_fz;
    logic [7:0]     w_sum_x;
    logic [7:0]     w_sum_y;
    logic [7:0]     w_sum_z;

    function automatic logic [7:0] sext(input logic [7:0] v, input logic [2:0] code);
        logic [7:0] mask;
        mask = 8'hff >> (3'd7 - code);
        sext = v[code] ? (v | ~mask) : (v & mask);
    endfunction

    assign w_has_res  = (i_op.cmd == dvbd_pkg::CMD_DECODE) || (i_op.cmd == dvbd_pkg::CMD_RAW);
    assign o_op_ready = !w_has_res || !r_out_valid || i_m_tready;
    assign w_go       = i_op_valid && o_op_ready;
    assign w_underrun = (7'(i_op.need) > r_cnt);

    assign w_top  = r_buf[63:40];
    assign w_wx   = 4'(i_op.code_x) + 4'd1;
    assign w_wy   = 4'(i_op.code_y) + 4'd1;
    assign w_wz   = 4'(i_op.code_z) + 4'd1;
    assign w_sh_y = w_top << w_wx;
    assign w_sh_z = w_top << (5'(w_wx) + 5'(w_wy));
    assign w_fx   = sext(8'(w_top >> (5'd24 - 5'(w_wx))), i_op.code_x);
    assign w_fy   = sext(8'(w_sh_y >> (5'd24 - 5'(w_wy))), i_op.code_y);
    assign w_fz   = sext(8'(w_sh_z >> (5'd24 - 5'(w_wz))), i_op.code_z);

    assign w_sum_x = ((i_op.code_x == 3'd7) ? 8'd0 : r_acc_x) + w_fx + i_op.byte_x;
    assign w_sum_y = ((i_op.code_y == 3'd7) ? 8'd0 : r_acc_y) + w_fy + i_op.byte_y;
    assign w_sum_z = ((i_op.code_z == 3'd7) ? 8'd0 : r_acc_z) + w_fz + i_op.byte_z;

    always_comb begin
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_acc_z     = r_acc_z;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        if (w_go) begin
            case (i_op.cmd)
                dvbd_pkg::CMD_START: begin
                    n_buf   = '0;
                    n_cnt   = '0;
                    n_acc_x = '0;
                    n_acc_y = '0;
                    n_acc_z = '0;
                end
                dvbd_pkg::CMD_LOAD: begin
                    if (r_cnt <= 7'd32) begin
                        n_buf = r_buf | ({i_op.word, 32'd0} >> r_cnt);
                        n_cnt = r_cnt + 7'd32;
                    end
                end
                dvbd_pkg::CMD_DECODE: begin
                    n_out_valid    = 1'b1;
                    n_out.out_slot = i_op.slot;
                    n_out.underrun = w_underrun;
                    if (w_underrun) begin
                        n_out.vert_x = '0;
                        n_out.vert_y = '0;
                        n_out.vert_z = '0;
                    end else begin
                        n_buf        = r_buf << i_op.need;
                        n_cnt        = r_cnt - 7'(i_op.need);
                        n_acc_x      = w_sum_x;
                        n_acc_y      = w_sum_y;
                        n_acc_z      = w_sum_z;
                        n_out.vert_x = w_sum_x;
                        n_out.vert_y = w_sum_z;
                        n_out.vert_z = w_sum_y;
                    end
                end
                dvbd_pkg::CMD_RAW: begin
                    n_out_valid    = 1'b1;
                    n_out.vert_x   = i_op.byte_x;
                    n_out.vert_y   = i_op.byte_y;
                    n_out.vert_z   = i_op.byte_z;
                    n_out.out_slot = i_op.slot;
                    n_out.underrun = 1'b0;
                end
                default: begin
                    n_out_valid = r_out_valid && !i_m_tready;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '0;
            r_cnt       <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_z     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            r_acc_z     <= n_acc_z;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'd64)
        else $error("bit count above 64");

    a_underrun_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.underrun |->
            r_out.vert_x == 8'd0 && r_out.vert_y == 8'd0 && r_out.vert_z == 8'd0)
        else $error("underrun result carries vertex data");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && i_op.cmd == dvbd_pkg::CMD_START |=>
            r_cnt == 7'd0 && r_buf == 64'd0 && r_acc_x == 8'd0 && r_acc_y == 8'd0
            && r_acc_z == 8'd0)
        else $error("start did not clear state");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && i_op.cmd == dvbd_pkg::CMD_LOAD && r_cnt <= 7'd32 |=>
            r_cnt == $past(r_cnt) + 7'd32)
        else $error("load did not add 32 bits");

    a_underrun_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && i_op.cmd == dvbd_pkg::CMD_DECODE && w_underrun |=>
            $stable(r_cnt) && $stable(r_acc_x) && $stable(r_acc_y) && $stable(r_acc_z))
        else $error("underrun consumed bits");
`endif

endmodule
`default_nettype wire

// ===== rtl/delta_vertex_bitstream_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Delta vertex bitstream decoder
// Unpacks delta coded vertex positions from a packed bit stream.
// ----------------------------------------------------------------------------
// The block takes one word per cycle on the slave side while the queue has
// room; decode and raw commands return one vertex word from the result
// register when the master side is ready. A QUEUE_DEPTH-entry queue links
// front and back end; the back end's combinational field extract and 8-bit
// accumulate set the rate of one word per cycle unless output stalls. Start
// and load words give no result. Underrun sets tuser and zeroes vertex bytes.
module delta_vertex_bitstream_decoder_top #(
    parameter int QUEUE_DEPTH = dvbd_pkg::QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tdata: stream_word[31:0], descriptor[63:32], raw_x[71:64], raw_y[79:72],
    //        raw_z[87:80], slot[95:88]
    input  wire logic [dvbd_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser: cmd[1:0]
    input  wire logic [1:0]                       i_s_tuser,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // tdata: vert_x[7:0], vert_y[15:8], vert_z[23:16], out_slot[31:24]
    output logic [dvbd_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    // tuser: underrun[0]
    output logic [0:0]                            o_m_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready
);

    dvbd_pkg::t_op  w_front_op;
    dvbd_pkg::t_op  w_queue_op;
    dvbd_pkg::t_res w_res;
    logic           w_queue_valid;
    logic           w_back_ready;

    dvbd_front u_front (
        .i_cmd  (i_s_tuser),
        .i_data (i_s_tdata),
        .o_op   (w_front_op)
    );

    dvbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_op    (w_front_op),
        .o_ready (o_s_tready),
        .o_valid (w_queue_valid),
        .i_pop   (w_back_ready),
        .o_op    (w_queue_op)
    );

    dvbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (w_queue_valid),
        .i_op       (w_queue_op),
        .o_op_ready (w_back_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (w_res)
    );

    assign o_m_tdata = {w_res.out_slot, w_res.vert_z, w_res.vert_y, w_res.vert_x};
    assign o_m_tuser = w_res.underrun;

endmodule
`default_nettype wire

// ===== test/tb_delta_vertex_bitstream_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delta vertex bitstream decoder testbench
// Feeds start, load, decode and raw words with random gaps on both sides and
// compares every vertex word against an in-bench model of the bit buffer and
// the axis accumulators.
// ----------------------------------------------------------------------------
module tb_delta_vertex_bitstream_decoder_top;

    localparam logic [2:0] CODE_CLEAR = 3'd7;
    localparam int         MAX_GAP    = 17;
    localparam int         RAND_WORDS = 550;

    class vertex_scoreboard;
        logic [63:0]    stream_bits;
        logic [6:0]     stream_fill;
        logic [7:0]     pos_x;
        logic [7:0]     pos_y;
        logic [7:0]     pos_z;
        dvbd_pkg::t_res pending_verts[$];
        int             errors;

        function new();
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            stream_bits = '0;
            stream_fill = '0;
            pos_x = '0;
            pos_y = '0;
            pos_z = '0;
        endfunction

        function logic [7:0] pull_field(int w);
            logic [63:0] top;
            logic [7:0]  f;
            top = stream_bits >> (64 - w);
            stream_bits = stream_bits << w;
            stream_fill = stream_fill - 7'(w);
            f = top[7:0];
            if (top[w-1]) begin
                f = f | (8'hff << w);
            end
            return f;
        endfunction

        function logic [7:0] step_axis(logic [7:0] acc, logic [2:0] code, logic [7:0] base);
            logic [7:0] start;
            start = (code == CODE_CLEAR) ? 8'd0 : acc;
            return start + pull_field(int'(code) + 1) + base;
        endfunction

        function void take_command(logic [1:0] cmd, logic [dvbd_pkg::IN_DATA_W-1:0] tdata);
            logic [31:0]    word;
            logic [31:0]    desc;
            logic [7:0]     slot;
            dvbd_pkg::t_res r;
            int             need;
            word = tdata[31:0];
            desc = tdata[63:32];
            slot = tdata[95:88];
            r = '0;
            r.out_slot = slot;
            case (cmd)
                dvbd_pkg::CMD_START: begin
                    clear_frame();
                end
                dvbd_pkg::CMD_LOAD: begin
                    if (stream_fill <= 7'd32) begin
                        stream_bits = stream_bits | ({32'h0, word} << (32 - int'(stream_fill)));
                        stream_fill = stream_fill + 7'd32;
                    end
                end
                dvbd_pkg::CMD_RAW: begin
                    r.vert_x = tdata[71:64];
                    r.vert_y = tdata[79:72];
                    r.vert_z = tdata[87:80];
                    pending_verts.push_back(r);
                end
                default: begin
                    need = int'(desc[8:6]) + int'(desc[5:3]) + int'(desc[2:0]) + 3;
                    if (int'(stream_fill) < need) begin
                        r.underrun = 1'b1;
                    end else begin
                        pos_x = step_axis(pos_x, desc[8:6], {desc[31:25], 1'b0});
                        pos_y = step_axis(pos_y, desc[5:3], desc[24:17]);
                        pos_z = step_axis(pos_z, desc[2:0], desc[16:9]);
                        r.vert_x = pos_x;
                        r.vert_y = pos_z;
                        r.vert_z = pos_y;
                    end
                    pending_verts.push_back(r);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_vertex(logic [dvbd_pkg::OUT_DATA_W-1:0] tdata, logic tuser);
            dvbd_pkg::t_res want;
            if (pending_verts.size() == 0) begin
                $display("%0t: unexpected vertex, expected none, actual %08h/%0b",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = pending_verts.pop_front();
            compare_field("vert_x", want.vert_x, tdata[7:0]);
            compare_field("vert_y", want.vert_y, tdata[15:8]);
            compare_field("vert_z", want.vert_z, tdata[23:16]);
            compare_field("out_slot", want.out_slot, tdata[31:24]);
            compare_field("underrun", 8'(want.underrun), 8'(tuser));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic [dvbd_pkg::IN_DATA_W-1:0]  i_s_tdata;   // stream_word, descriptor, raw_x, raw_y, raw_z, slot
    logic [1:0]                      i_s_tuser;   // cmd
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [dvbd_pkg::OUT_DATA_W-1:0] o_m_tdata;   // vert_x, vert_y, vert_z, out_slot
    logic [0:0]                      o_m_tuser;   // underrun
    logic                            o_m_tvalid;
    logic                            i_m_tready;

    vertex_scoreboard sb;
    bit               tx_quiet;
    bit               rx_quiet;

    delta_vertex_bitstream_decoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] make_desc(logic [2:0] cx, logic [2:0] cy, logic [2:0] cz,
                                              logic [6:0] bx, logic [7:0] by, logic [7:0] bz);
        return {bx, by, bz, cx, cy, cz};
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [31:0] word, logic [31:0] desc,
                             logic [7:0] rx, logic [7:0] ry, logic [7:0] rz, logic [7:0] slot);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tdata  <= {slot, rz, ry, rx, desc, word};
        i_s_tuser  <= cmd;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.take_command(cmd, {slot, rz, ry, rx, desc, word});
    endtask

    task automatic send_load(logic [31:0] word);
        send_word(dvbd_pkg::CMD_LOAD, word, $urandom, 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    task automatic send_decode(logic [31:0] desc, logic [7:0] slot);
        send_word(dvbd_pkg::CMD_DECODE, $urandom, desc, 8'($urandom), 8'($urandom),
                  8'($urandom), slot);
    endtask

    task automatic send_raw(logic [7:0] rx, logic [7:0] ry, logic [7:0] rz, logic [7:0] slot);
        send_word(dvbd_pkg::CMD_RAW, $urandom, $urandom, rx, ry, rz, slot);
    endtask

    task automatic send_start();
        send_word(dvbd_pkg::CMD_START, $urandom, $urandom, 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    task automatic drain_vertices();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending_verts.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_receiver();
        int stall;
        int taken;
        taken = 0;
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_vertex(o_m_tdata, o_m_tuser[0]);
            taken++;
            if (taken % 25 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic run_directed();
        send_decode(make_desc(3'd0, 3'd0, 3'd0, 7'h00, 8'h00, 8'h00), 8'hff);
        send_raw(8'h00, 8'h00, 8'h00, 8'h00);
        send_raw(8'hff, 8'hff, 8'hff, 8'hff);
        send_load(32'h8000_0001);
        send_load(32'hffff_ffff);
        send_load(32'h1234_5678);
        send_decode(32'hffff_ffff, 8'h01);
        send_decode(32'h0000_0000, 8'h02);
        send_load(32'hdead_beef);
        send_decode(make_desc(3'd7, 3'd7, 3'd7, 7'h00, 8'h00, 8'h00), 8'h03);
        send_decode(make_desc(3'd7, 3'd7, 3'd7, 7'h55, 8'haa, 8'h55), 8'h04);
        send_decode(make_desc(3'd3, 3'd3, 3'd3, 7'h7f, 8'h80, 8'h7f), 8'h05);
        send_load(32'h0000_0000);
        send_load(32'hffff_ffff);
        send_decode(make_desc(3'd2, 3'd5, 3'd0, 7'h01, 8'hfe, 8'h01), 8'h06);
        send_decode(make_desc(3'd7, 3'd0, 3'd7, 7'h40, 8'h20, 8'h10), 8'h07);
        send_start();
        send_decode(make_desc(3'd0, 3'd0, 3'd0, 7'h7f, 8'hff, 8'hff), 8'h08);
        send_load(32'ha5a5_5a5a);
        send_load(32'h0f0f_f0f0);
        send_decode(make_desc(3'd7, 3'd7, 3'd7, 7'h2a, 8'h15, 8'hc3), 8'h09);
        send_raw(8'h5a, 8'ha5, 8'h3c, 8'h80);
        send_start();
        send_decode(32'hffff_ffff, 8'h7f);
    endtask

    task automatic run_random();
        int pick;
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 30 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n % 150 == 149) begin
                drain_vertices();
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_start();
            end else if (pick < 31) begin
                send_load($urandom);
            end else if (pick < 88) begin
                send_decode($urandom, 8'($urandom));
            end else begin
                send_raw(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("** delta_vertex_bitstream_decoder_top: FAILED **");
        $finish;
    end

    initial begin
        sb         = new();
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = dvbd_pkg::CMD_START;
        i_s_tvalid = 1'b0;
        i_m_tready = 1'b0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            run_receiver();
        join_none
        run_directed();
        drain_vertices();
        run_random();
        drain_vertices();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_verts.size() == 0) begin
            $display("** delta_vertex_bitstream_decoder_top: PASSED **");
        end else begin
            $display("** delta_vertex_bitstream_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule
